[hw/rtl/fan_curve_controller_assert.svh]
// Assertion macros used by the fan curve controller top level.
`ifndef FAN_CURVE_CONTROLLER_ASSERT_SVH
`define FAN_CURVE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FCC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fan curve controller check failed");

// Next-cycle implication, checked outside reset.
`define FCC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fan curve controller check failed");

`endif

[hw/rtl/fcc_pkg.sv]
// Types, constants and codes for the fan curve controller.
package fcc_pkg;

  localparam int TEMP_W = 17;
  localparam int DUTY_W = 16;
  localparam int RPM_W = 16;
  localparam int FAN_W = 3;
  localparam int DUTYC_W = 15;

  localparam int DEF_MAX_POINTS = 16;
  localparam int DEF_FAN_SLOTS = 8;

  localparam int DUTY_FULL = 25600;
  localparam int SENSOR_LIMIT = 51200;
  localparam int COLD_LIMIT = -12800;

  // The rpm mix is divided by 25600 as a shift by 10 and a multiply by a
  // rounded-up reciprocal of 25, exact for every mix the block can form.
  localparam int MIX_SHIFT = 10;
  localparam int RECIP_W = 22;
  localparam int RECIP_SHIFT = 26;
  localparam logic [RECIP_W-1:0] MIX_RECIP = 22'd2684355;

  localparam int DIV_N_W = 35;
  localparam int DIV_D_W = 18;
  localparam int DIV_Q_W = 17;

  localparam logic [TEMP_W-1:0] EMERG_RESET = 17'd24320;
  localparam logic [RPM_W-1:0] SLEW_RESET = 16'd800;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_SENSE = 2'd2,
    MODE_EVAL  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_CURVE = 2'd0,
    STAT_EMERG = 2'd1,
    STAT_COLD  = 2'd2,
    STAT_AUTO  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_ACTIVE = 2'd0,
    CFG_EMERG  = 2'd1,
    CFG_SLEW   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SEG_NONE = 2'd0,
    SEG_LOW  = 2'd1,
    SEG_MID  = 2'd2,
    SEG_HIGH = 2'd3
  } seg_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_D1GO,
    S_DIV1,
    S_DUTY,
    S_MIXA,
    S_MIXB,
    S_D2GO,
    S_SLEW
  } state_t;

  typedef struct packed {
    seg_kind_t kind;
    logic [TEMP_W-1:0] lo_t;
    logic [TEMP_W-1:0] hi_t;
    logic [DUTY_W-1:0] lo_d;
    logic [DUTY_W-1:0] hi_d;
  } seg_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    logic [DUTY_W-1:0] duty;
    logic gt;
    logic ge;
    seg_t seg;
  } cell_link_t;

  typedef struct packed {
    logic ins_en;
    logic [TEMP_W-1:0] ins_temp;
    logic [DUTY_W-1:0] ins_duty;
    logic [TEMP_W-1:0] eval_t;
    logic low_hit;
  } cell_ctl_t;

endpackage

[hw/rtl/fcc_cell.sv]
// One curve point cell: holds a point, shifts on insert and passes the segment search on.
module fcc_cell import fcc_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic       occ,
  input  logic       slot_free,
  input  logic       is_last,
  input  cell_link_t nb,
  output cell_link_t link
);

  logic signed [TEMP_W-1:0] temp_r, temp_nxt;
  logic [DUTY_W-1:0] duty_r, duty_nxt;
  seg_t seg_r, seg_nxt;
  logic ge, gt, take;

  always_comb begin
    ge = occ && (temp_r >= $signed(ctl.eval_t));
    gt = occ && (temp_r > $signed(ctl.ins_temp));
    take = ctl.ins_en && (slot_free || gt);
    temp_nxt = temp_r;
    duty_nxt = duty_r;
    if (take) begin
      temp_nxt = nb.gt ? $signed(nb.temp) : $signed(ctl.ins_temp);
      duty_nxt = nb.gt ? nb.duty : ctl.ins_duty;
    end
    seg_nxt = nb.seg;
    if (is_last && occ && (temp_r <= $signed(ctl.eval_t)) && !ctl.low_hit) begin
      seg_nxt.kind = SEG_HIGH;
      seg_nxt.hi_d = duty_r;
    end else if (ge && !nb.ge) begin
      seg_nxt.kind = (INDEX == 0) ? SEG_LOW : SEG_MID;
      seg_nxt.lo_t = nb.temp;
      seg_nxt.hi_t = temp_r;
      seg_nxt.lo_d = nb.duty;
      seg_nxt.hi_d = duty_r;
    end
  end

  always_ff @(posedge clk) begin
    temp_r <= temp_nxt;
    duty_r <= duty_nxt;
    seg_r <= seg_nxt;
  end

  assign link.temp = temp_r;
  assign link.duty = duty_r;
  assign link.gt = gt;
  assign link.ge = ge;
  assign link.seg = seg_r;

endmodule

[hw/rtl/fcc_divider.sv]
// Restoring divider that produces one quotient bit per cycle.
module fcc_divider import fcc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_N_W-1:0] num,
  input  logic [DIV_D_W-1:0] den,
  output logic               done,
  output logic [DIV_Q_W-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_Q_W + 1);

  logic [DIV_D_W-1:0] rem_r, rem_nxt;
  logic [DIV_Q_W-1:0] q_r, q_nxt;
  logic [DIV_D_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic done_r, done_nxt;
  logic [DIV_D_W:0] trial;
  logic fits;

  always_comb begin
    trial = {rem_r, q_r[DIV_Q_W-1]};
    fits = trial >= {1'b0, den_r};
    rem_nxt = rem_r;
    q_nxt = q_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = num[DIV_N_W-1:DIV_Q_W];
      q_nxt = num[DIV_Q_W-1:0];
      den_nxt = den;
      cnt_nxt = CNT_W'(DIV_Q_W);
    end else if (cnt_r != '0) begin
      rem_nxt = fits ? DIV_D_W'(trial - {1'b0, den_r}) : trial[DIV_D_W-1:0];
      q_nxt = {q_r[DIV_Q_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo = q_r;

endmodule

[hw/rtl/fan_curve_controller.sv]
// Fan curve controller top level: curve cells, sensor maximum, evaluation sequencer.
//
//  Port group   Direction  Handshake
//  in_*         input      start high while busy low moves one transfer
//  out_*        output     out_valid high for one cycle per transfer
//  cfg_*        input      cfg_we high writes register cfg_index
//
// Clear, add-point and sensor items keep busy low.
// Evaluation keeps busy high while the segment search walks the cell chain and, when the
// reading falls inside the curve, while the divider delivers one quotient bit per cycle;
// the duty, rpm mix and slew steps follow. The result appears in the first cycle with
// busy low. Automatic, no-sensor and too-cold results appear in the cycle after the
// transfer. Reset is synchronous and active low; the result receiver cannot stall.
`include "fan_curve_controller_assert.svh"
module fan_curve_controller import fcc_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int FAN_SLOTS = DEF_FAN_SLOTS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_mode,
  input  logic signed [TEMP_W-1:0] in_temperature,
  input  logic signed [DUTY_W-1:0] in_point_duty,
  input  logic                     in_sensor_ok,
  input  logic                     in_scan_first,
  input  logic [FAN_W-1:0]         in_fan_index,
  input  logic [RPM_W-1:0]         in_fan_min_rpm,
  input  logic [RPM_W-1:0]         in_fan_max_rpm,
  output logic                     out_valid,
  output logic [FAN_W-1:0]         out_fan_number,
  output logic [RPM_W-1:0]         out_target_rpm,
  output logic [1:0]               out_status,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [TEMP_W-1:0]        cfg_wdata
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int FW = (FAN_SLOTS > 1) ? $clog2(FAN_SLOTS) : 1;
  localparam int RP_W = 2 * RECIP_W;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic signed [TEMP_W-1:0] hot_r, hot_nxt;
  logic seen_r, seen_nxt;
  logic act_r, act_nxt;
  logic signed [TEMP_W-1:0] emerg_r, emerg_nxt;
  logic [RPM_W-1:0] slew_r, slew_nxt;
  logic [FAN_W-1:0] fan_r, fan_nxt;
  logic [RPM_W-1:0] mn_r, mn_nxt, mx_r, mx_nxt;
  logic signed [DIV_N_W-1:0] prod_r, prod_nxt;
  logic [DUTYC_W-1:0] duty_r, duty_nxt;
  status_t stat_r, stat_nxt;
  logic [30:0] a_r, a_nxt;
  logic [31:0] x_r, x_nxt;
  logic [RP_W-1:0] rp_r, rp_nxt;
  logic ov_r, ov_nxt;
  logic [FAN_W-1:0] of_r, of_nxt;
  logic [RPM_W-1:0] ot_r, ot_nxt;
  status_t os_r, os_nxt;

  logic [RPM_W-1:0] hist_r [FAN_SLOTS];
  logic [FAN_SLOTS-1:0] hv_r;
  logic hist_we, hv_clr;
  logic [FW-1:0] hidx;
  logic [RPM_W-1:0] hist_wd;

  cell_ctl_t ctl;
  cell_link_t links [MAX_POINTS+1];
  seg_t seg;

  logic div_start, div_done;
  logic [DIV_N_W-1:0] div_num;
  logic [DIV_D_W-1:0] div_den;
  logic [DIV_Q_W-1:0] div_q;

  logic accept, seen_eff, fan_slot, in_slot;
  logic signed [TEMP_W:0] diff_t, span;
  logic signed [DUTY_W:0] dd;
  logic [DIV_N_W-1:0] mag;
  logic signed [DUTY_W+1:0] duty_s;
  logic signed [DIV_Q_W:0] q_s;
  logic signed [RPM_W+1:0] sdiff, sl, tgt_s;
  logic [RPM_W-1:0] last, tgt;

  assign links[0] = '0;
  assign seg = links[MAX_POINTS].seg;

  always_comb begin
    ctl.ins_en = (state_r == S_IDLE) && start && (in_mode == MODE_ADD)
                 && (count_r < CW'(MAX_POINTS));
    ctl.ins_temp = in_temperature;
    ctl.ins_duty = in_point_duty;
    ctl.eval_t = hot_r;
    ctl.low_hit = links[1].ge;
  end

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    fcc_cell #(.INDEX(i)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (count_r > CW'(i)),
      .slot_free (count_r == CW'(i)),
      .is_last   (count_r == CW'(i + 1)),
      .nb        (links[i]),
      .link      (links[i+1])
    );
  end

  fcc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    accept = (state_r == S_IDLE) && start;
    in_slot = 32'(in_fan_index) < FAN_SLOTS;
    fan_slot = 32'(fan_r) < FAN_SLOTS;
    hidx = (state_r == S_IDLE) ? FW'(in_fan_index) : FW'(fan_r);
    seen_eff = seen_r && !in_scan_first;

    diff_t = (TEMP_W+1)'(hot_r) - (TEMP_W+1)'($signed(seg.lo_t));
    span = (TEMP_W+1)'($signed(seg.hi_t)) - (TEMP_W+1)'($signed(seg.lo_t));
    dd = (DUTY_W+1)'($signed(seg.hi_d)) - (DUTY_W+1)'($signed(seg.lo_d));
    mag = prod_r[DIV_N_W-1] ? DIV_N_W'(-prod_r) : DIV_N_W'(prod_r);
    q_s = (DIV_Q_W+1)'({1'b0, div_q});

    div_start = (state_r == S_D1GO);
    div_num = DIV_N_W'(mag + DIV_N_W'(span[TEMP_W:1]));
    div_den = DIV_D_W'(span);

    last = hist_r[hidx];
    tgt_s = (RPM_W+2)'(rp_r[RECIP_SHIFT +: RPM_W]);
    sl = (RPM_W+2)'(slew_r);
    sdiff = tgt_s - (RPM_W+2)'(last);
    if (hv_r[hidx] && fan_slot) begin
      if (sdiff > sl) tgt_s = (RPM_W+2)'(last) + sl;
      else if (sdiff < -sl) tgt_s = (RPM_W+2)'(last) - sl;
    end
    tgt = tgt_s[RPM_W-1:0];
    if (tgt < mn_r) tgt = mn_r;
    if (tgt > mx_r) tgt = mx_r;

    if (state_r == S_DUTY && seg.kind == SEG_MID) begin
      duty_s = (DUTY_W+2)'($signed(seg.lo_d)) + (prod_r[DIV_N_W-1] ? -q_s : q_s);
    end else begin
      duty_s = (DUTY_W+2)'($signed(seg.hi_d));
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cnt_nxt = cnt_r;
    hot_nxt = hot_r;
    seen_nxt = seen_r;
    act_nxt = act_r;
    emerg_nxt = emerg_r;
    slew_nxt = slew_r;
    fan_nxt = fan_r;
    mn_nxt = mn_r;
    mx_nxt = mx_r;
    prod_nxt = prod_r;
    duty_nxt = duty_r;
    stat_nxt = stat_r;
    a_nxt = a_r;
    x_nxt = x_r;
    rp_nxt = rp_r;
    ov_nxt = 1'b0;
    of_nxt = of_r;
    ot_nxt = ot_r;
    os_nxt = os_r;
    hist_we = 1'b0;
    hv_clr = 1'b0;
    hist_wd = tgt_s[RPM_W-1:0];

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACTIVE: act_nxt = cfg_wdata[0];
        CFG_EMERG:  emerg_nxt = cfg_wdata;
        CFG_SLEW:   slew_nxt = cfg_wdata[RPM_W-1:0];
        default:    act_nxt = act_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_CLEAR: count_nxt = '0;
            MODE_ADD: begin
              if (ctl.ins_en) count_nxt = count_r + 1'b1;
            end
            MODE_SENSE: begin
              seen_nxt = seen_eff;
              if (in_sensor_ok && (in_temperature < (TEMP_W+1)'(SENSOR_LIMIT))
                  && (!seen_eff || in_temperature > hot_r)) begin
                hot_nxt = in_temperature;
                seen_nxt = 1'b1;
              end
            end
            default: begin
              fan_nxt = in_fan_index;
              mn_nxt = in_fan_min_rpm;
              mx_nxt = in_fan_max_rpm;
              of_nxt = in_fan_index;
              if (!act_r || count_r < CW'(2)) begin
                hv_clr = in_slot;
                ov_nxt = 1'b1;
                ot_nxt = '0;
                os_nxt = STAT_AUTO;
              end else if (!seen_r || hot_r < TEMP_W'(COLD_LIMIT)) begin
                ov_nxt = 1'b1;
                ot_nxt = in_fan_max_rpm;
                os_nxt = STAT_COLD;
              end else begin
                cnt_nxt = '0;
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(MAX_POINTS - 1)) begin
          state_nxt = (seg.kind == SEG_MID) ? S_MUL : S_DUTY;
        end
      end
      S_MUL: begin
        prod_nxt = DIV_N_W'(diff_t) * DIV_N_W'(dd);
        state_nxt = S_D1GO;
      end
      S_D1GO: state_nxt = S_DIV1;
      S_DIV1: begin
        if (div_done) state_nxt = S_DUTY;
      end
      S_DUTY: begin
        stat_nxt = STAT_CURVE;
        if (hot_r >= emerg_r) begin
          duty_nxt = DUTYC_W'(DUTY_FULL);
          stat_nxt = STAT_EMERG;
        end else if (duty_s < 0) begin
          duty_nxt = '0;
        end else if (duty_s > (DUTY_W+2)'(DUTY_FULL)) begin
          duty_nxt = DUTYC_W'(DUTY_FULL);
        end else begin
          duty_nxt = duty_s[DUTYC_W-1:0];
        end
        state_nxt = S_MIXA;
      end
      S_MIXA: begin
        a_nxt = 31'(mn_r) * 31'(DUTYC_W'(DUTY_FULL) - duty_r);
        state_nxt = S_MIXB;
      end
      S_MIXB: begin
        x_nxt = 32'(a_r) + 32'(mx_r) * 32'(duty_r) + 32'(DUTY_FULL / 2);
        state_nxt = S_D2GO;
      end
      S_D2GO: begin
        rp_nxt = RP_W'(x_r[31:MIX_SHIFT]) * RP_W'(MIX_RECIP);
        state_nxt = S_SLEW;
      end
      S_SLEW: begin
        hist_we = fan_slot;
        ov_nxt = 1'b1;
        of_nxt = fan_r;
        ot_nxt = tgt;
        os_nxt = stat_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      hot_r <= '0;
      seen_r <= 1'b0;
      act_r <= 1'b0;
      emerg_r <= EMERG_RESET;
      slew_r <= SLEW_RESET;
      ov_r <= 1'b0;
      hv_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      hot_r <= hot_nxt;
      seen_r <= seen_nxt;
      act_r <= act_nxt;
      emerg_r <= emerg_nxt;
      slew_r <= slew_nxt;
      ov_r <= ov_nxt;
      if (hv_clr) hv_r[hidx] <= 1'b0;
      if (hist_we) hv_r[hidx] <= 1'b1;
    end
    cnt_r <= cnt_nxt;
    fan_r <= fan_nxt;
    mn_r <= mn_nxt;
    mx_r <= mx_nxt;
    prod_r <= prod_nxt;
    duty_r <= duty_nxt;
    stat_r <= stat_nxt;
    a_r <= a_nxt;
    x_r <= x_nxt;
    rp_r <= rp_nxt;
    of_r <= of_nxt;
    ot_r <= ot_nxt;
    os_r <= os_nxt;
    if (hist_we) hist_r[hidx] <= hist_wd;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_fan_number = of_r;
  assign out_target_rpm = ot_r;
  assign out_status = os_r;

  `FCC_ASSERT_IMP(a_out_when_idle, out_valid, !busy)
  `FCC_ASSERT_IMP(a_auto_zero, out_valid && out_status == STAT_AUTO, out_target_rpm == '0)
  `FCC_ASSERT_IMP(a_count_bound, busy, count_r <= CW'(MAX_POINTS) && count_r >= CW'(2))
  `FCC_ASSERT_NXT(a_busy_from_eval, !busy && !(start && in_mode == MODE_EVAL), !busy)

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the fan curve controller: directed and random items.
module tb_top import fcc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 80;

  typedef struct {
    logic [FAN_W-1:0] fan;
    logic [RPM_W-1:0] rpm;
    status_t          status;
  } fan_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [1:0]               in_mode;
  logic signed [TEMP_W-1:0] in_temperature;
  logic signed [DUTY_W-1:0] in_point_duty;
  logic                     in_sensor_ok;
  logic                     in_scan_first;
  logic [FAN_W-1:0]         in_fan_index;
  logic [RPM_W-1:0]         in_fan_min_rpm;
  logic [RPM_W-1:0]         in_fan_max_rpm;
  logic                     out_valid;
  logic [FAN_W-1:0]         out_fan_number;
  logic [RPM_W-1:0]         out_target_rpm;
  logic [1:0]               out_status;
  logic                     cfg_we;
  logic [1:0]               cfg_index;
  logic [TEMP_W-1:0]        cfg_wdata;

  fan_curve_controller u_top (.*);

  // Shadow state of the controller.
  logic signed [TEMP_W-1:0] curve_temp [DEF_MAX_POINTS];
  logic signed [DUTY_W-1:0] curve_duty_pt [DEF_MAX_POINTS];
  int                       curve_len;
  logic signed [TEMP_W-1:0] hottest;
  bit                       hottest_ok;
  longint                   prev_target [DEF_FAN_SLOTS];
  bit                       prev_ok [DEF_FAN_SLOTS];
  bit                       cur_active;
  logic signed [TEMP_W-1:0] cur_emerg;
  logic [RPM_W-1:0]         cur_slew;

  fan_result_t pending_rpm[$];
  int          mismatches = 0;
  int          idle_pct;
  int          stall_count = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint curve_lookup(longint t);
    longint lo, hi, span, num, q;
    if (t <= curve_temp[0]) return curve_duty_pt[0];
    if (t >= curve_temp[curve_len-1]) return curve_duty_pt[curve_len-1];
    for (int i = 0; i < curve_len - 1; i++) begin
      lo = curve_temp[i];
      hi = curve_temp[i+1];
      if (t >= lo && t <= hi) begin
        span = hi - lo;
        if (span <= 0) return curve_duty_pt[i+1];
        num = (t - lo) * (longint'(curve_duty_pt[i+1]) - longint'(curve_duty_pt[i]));
        if (num >= 0) q = (num + span / 2) / span;
        else q = -((-num + span / 2) / span);
        return longint'(curve_duty_pt[i]) + q;
      end
    end
    return curve_duty_pt[curve_len-1];
  endfunction

  function automatic void predict_fan(mode_t m, logic signed [TEMP_W-1:0] t,
      logic signed [DUTY_W-1:0] d, bit ok, bit first, logic [FAN_W-1:0] f,
      logic [RPM_W-1:0] mn, logic [RPM_W-1:0] mx);
    int pos;
    longint duty, tgt, diff;
    fan_result_t r;
    case (m)
      MODE_CLEAR: curve_len = 0;
      MODE_ADD: begin
        if (curve_len < DEF_MAX_POINTS) begin
          pos = curve_len;
          while (pos > 0 && curve_temp[pos-1] > t) begin
            curve_temp[pos] = curve_temp[pos-1];
            curve_duty_pt[pos] = curve_duty_pt[pos-1];
            pos--;
          end
          curve_temp[pos] = t;
          curve_duty_pt[pos] = d;
          curve_len++;
        end
      end
      MODE_SENSE: begin
        if (first) hottest_ok = 0;
        if (ok && t < SENSOR_LIMIT && (!hottest_ok || t > hottest)) begin
          hottest = t;
          hottest_ok = 1;
        end
      end
      default: begin
        r.fan = f;
        if (!cur_active || curve_len < 2) begin
          prev_ok[f] = 0;
          prev_target[f] = 0;
          r.rpm = 0;
          r.status = STAT_AUTO;
        end else if (!hottest_ok || hottest < COLD_LIMIT) begin
          r.rpm = mx;
          r.status = STAT_COLD;
        end else begin
          duty = curve_lookup(hottest);
          r.status = STAT_CURVE;
          if (hottest >= cur_emerg) begin
            duty = DUTY_FULL;
            r.status = STAT_EMERG;
          end
          if (duty < 0) duty = 0;
          if (duty > DUTY_FULL) duty = DUTY_FULL;
          tgt = (longint'(mn) * (DUTY_FULL - duty) + longint'(mx) * duty + DUTY_FULL / 2)
                / DUTY_FULL;
          if (prev_ok[f]) begin
            diff = tgt - prev_target[f];
            if (diff > longint'(cur_slew)) tgt = prev_target[f] + longint'(cur_slew);
            if (diff < -longint'(cur_slew)) tgt = prev_target[f] - longint'(cur_slew);
          end
          prev_target[f] = tgt;
          prev_ok[f] = 1;
          if (tgt < longint'(mn)) tgt = longint'(mn);
          if (tgt > longint'(mx)) tgt = longint'(mx);
          r.rpm = tgt[RPM_W-1:0];
        end
        pending_rpm.push_back(r);
      end
    endcase
  endfunction

  task automatic send_item(mode_t m, logic signed [TEMP_W-1:0] t,
      logic signed [DUTY_W-1:0] d, bit ok, bit first, logic [FAN_W-1:0] f,
      logic [RPM_W-1:0] mn, logic [RPM_W-1:0] mx);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1;
    in_mode <= m;
    in_temperature <= t;
    in_point_duty <= d;
    in_sensor_ok <= ok;
    in_scan_first <= first;
    in_fan_index <= f;
    in_fan_min_rpm <= mn;
    in_fan_max_rpm <= mx;
    do @(posedge clk); while (busy);
    predict_fan(m, t, d, ok, first, f, mn, mx);
  endtask

  task automatic drain_results();
    start <= 0;
    @(posedge clk);
    while (pending_rpm.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [TEMP_W-1:0] val);
    drain_results();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_ACTIVE: cur_active = val[0];
      CFG_EMERG:  cur_emerg = val;
      default:    cur_slew = val[RPM_W-1:0];
    endcase
  endtask

  function automatic logic signed [TEMP_W-1:0] pick_temp();
    if ($urandom_range(9) < 8) return TEMP_W'($urandom_range(48000) - 16000);
    return TEMP_W'($urandom);
  endfunction

  task automatic test_auto_and_short();
    send_item(MODE_EVAL, 0, 0, 0, 0, 3'd0, 16'd1000, 16'd6000);
    write_reg(CFG_ACTIVE, 1);
    send_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    send_item(MODE_ADD, 17'sd7680, 16'sd5120, 0, 0, 0, 0, 0);
    send_item(MODE_EVAL, 0, 0, 0, 0, 3'd7, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_curve_shape();
    send_item(MODE_ADD, -17'sd65536, -16'sd32768, 0, 0, 0, 0, 0);
    send_item(MODE_ADD, 17'sd65535, 16'sd32767, 0, 0, 0, 0, 0);
    send_item(MODE_ADD, 17'sd7680, 16'sd20000, 0, 0, 0, 0, 0);
    send_item(MODE_EVAL, 0, 0, 0, 0, 3'd1, 16'd1000, 16'd6000);
    send_item(MODE_SENSE, 17'sd7680, 0, 1, 1, 0, 0, 0);
    send_item(MODE_EVAL, 0, 0, 0, 0, 3'd1, 16'd1000, 16'd6000);
    send_item(MODE_SENSE, 17'sd51200, 0, 1, 0, 0, 0, 0);
    send_item(MODE_SENSE, 17'sd9000, 0, 0, 0, 0, 0, 0);
    send_item(MODE_SENSE, 17'sd51199, 0, 1, 0, 0, 0, 0);
    send_item(MODE_EVAL, 0, 0, 0, 0, 3'd2, 16'd6000, 16'd1000);
    send_item(MODE_SENSE, -17'sd12801, 0, 1, 1, 0, 0, 0);
    send_item(MODE_EVAL, 0, 0, 0, 0, 3'd3, 16'd0, 16'd65535);
    send_item(MODE_SENSE, -17'sd20000, 0, 1, 1, 0, 0, 0);
    send_item(MODE_EVAL, 0, 0, 0, 0, 3'd4, 16'd500, 16'd3000);
  endtask

  task automatic test_full_curve();
    send_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < DEF_MAX_POINTS + 1; i++)
      send_item(MODE_ADD, 17'(2560 * (i / 2)), 16'(1600 * i), 0, 0, 0, 0, 0);
    send_item(MODE_SENSE, 17'sd2560, 0, 1, 1, 0, 0, 0);
    send_item(MODE_EVAL, 0, 0, 0, 0, 3'd5, 16'd0, 16'd9000);
  endtask

  task automatic test_random(int count);
    int sent, k;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 75) begin
        if ($urandom_range(99) < 40) begin
          send_item(MODE_CLEAR, TEMP_W'($urandom), DUTY_W'($urandom), 1'($urandom),
                    1'($urandom), FAN_W'($urandom), RPM_W'($urandom), RPM_W'($urandom));
          k = $urandom_range(1, DEF_MAX_POINTS + 2);
          for (int i = 0; i < k; i++)
            send_item(MODE_ADD, pick_temp(),
                      ($urandom_range(9) < 8) ? 16'($urandom_range(DUTY_FULL)) : 16'($urandom),
                      1'($urandom), 1'($urandom), FAN_W'($urandom), RPM_W'($urandom),
                      RPM_W'($urandom));
          sent += k + 1;
        end
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++)
          send_item(MODE_SENSE, pick_temp(), DUTY_W'($urandom), $urandom_range(9) != 0,
                    i == 0, FAN_W'($urandom), RPM_W'($urandom), RPM_W'($urandom));
        sent += k;
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(9) < 7)
            send_item(MODE_EVAL, TEMP_W'($urandom), DUTY_W'($urandom), 1'($urandom),
                      1'($urandom), FAN_W'($urandom),
                      16'($urandom_range(3000)), 16'($urandom_range(2000, 12000)));
          else
            send_item(MODE_EVAL, TEMP_W'($urandom), DUTY_W'($urandom), 1'($urandom),
                      1'($urandom), FAN_W'($urandom), RPM_W'($urandom), RPM_W'($urandom));
        end
        sent += k;
      end else begin
        send_item(mode_t'($urandom_range(3)), TEMP_W'($urandom), DUTY_W'($urandom),
                  1'($urandom), 1'($urandom), FAN_W'($urandom), RPM_W'($urandom),
                  RPM_W'($urandom));
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    fan_result_t r;
    if (rst_n && out_valid) begin
      if (pending_rpm.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: fan %0d rpm %0d status %0d",
                   out_fan_number, out_target_rpm, out_status);
      end else begin
        r = pending_rpm.pop_front();
        if (out_fan_number !== r.fan || out_target_rpm !== r.rpm ||
            out_status !== r.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected fan %0d rpm %0d status %0d, got %0d %0d %0d",
                     r.fan, r.rpm, r.status, out_fan_number, out_target_rpm, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    idle_pct = 7;
    curve_len = 0;
    hottest = 0;
    hottest_ok = 0;
    cur_active = 0;
    cur_emerg = EMERG_RESET;
    cur_slew = SLEW_RESET;
    for (int i = 0; i < DEF_FAN_SLOTS; i++) begin
      prev_target[i] = 0;
      prev_ok[i] = 0;
    end
    rst_n = 0;
    start = 0;
    in_mode = MODE_CLEAR;
    in_temperature = 0;
    in_point_duty = 0;
    in_sensor_ok = 0;
    in_scan_first = 0;
    in_fan_index = 0;
    in_fan_min_rpm = 0;
    in_fan_max_rpm = 0;
    cfg_we = 0;
    cfg_index = CFG_ACTIVE;
    cfg_wdata = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    test_auto_and_short();
    test_curve_shape();
    test_full_curve();

    write_reg(CFG_SLEW, 17'd0);
    write_reg(CFG_EMERG, 17'h10000);
    test_random(150);
    write_reg(CFG_SLEW, 17'h0FFFF);
    write_reg(CFG_EMERG, 17'h0FFFF);
    test_random(300);
    write_reg(CFG_SLEW, 17'd250);
    write_reg(CFG_EMERG, 17'd10000);
    test_random(200);

    idle_pct = 63;
    write_reg(CFG_ACTIVE, 0);
    test_random(100);
    write_reg(CFG_ACTIVE, 1);
    write_reg(CFG_SLEW, 17'd1500);
    test_random(550);

    idle_pct = 0;
    write_reg(CFG_EMERG, 17'd5120);
    test_random(300);
    write_reg(CFG_EMERG, EMERG_RESET);
    write_reg(CFG_SLEW, TEMP_W'(SLEW_RESET));
    test_random(350);

    drain_results();
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
